/* src/gcd_pkg.sv */
// Shared constants and tables for the great-circle distance datapath.
package gcd_pkg;

	localparam int ANGLE_FRAC_BITS = 20;
	localparam int DIST_FRAC_BITS  = 8;

	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STEPS   = 31;

	localparam logic [31:0] CONV_FULL   = 32'd3054198966;
	localparam logic [31:0] CONV_HALF   = 32'd1527099483;
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
	localparam logic [32:0] DIST_SCALE  = 33'd5246834913;
	localparam logic [22:0] OUT_MAX     = 23'h7FFFFF;
	localparam logic [30:0] Q30_ONE     = 31'h40000000;

	localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

endpackage

/* src/gcd_sincos.sv */
// Pipelined rotation CORDIC: sine and cosine of a 32-bit binary angle, Q30.
module gcd_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        bam,
	output logic signed [32:0] sin_val,
	output logic signed [32:0] cos_val
);

	localparam int N = gcd_pkg::CORDIC_STEPS;

	logic signed [32:0] x_s [N];
	logic signed [32:0] y_s [N];
	logic signed [32:0] z_s [N];
	logic [1:0]         q_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [32:0] ANG = 33'(gcd_pkg::ATAN_TAB[i]);
		logic signed [32:0] xi, yi, zi, dx, dy;
		logic [1:0]         qi;
		if (i == 0) begin : g_first
			assign xi = 33'(gcd_pkg::CORDIC_GAIN);
			assign yi = '0;
			assign zi = {3'b000, bam[29:0]};
			assign qi = bam[31:30];
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign qi = q_s[i-1];
		end
		assign dx = yi >>> i;
		assign dy = xi >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i] <= qi;
				if (zi >= 0) begin
					x_s[i] <= xi - dx;
					y_s[i] <= yi + dy;
					z_s[i] <= zi - ANG;
				end else begin
					x_s[i] <= xi + dx;
					y_s[i] <= yi - dy;
					z_s[i] <= zi + ANG;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[N-1])
				2'd0: begin
					sin_val <= y_s[N-1];
					cos_val <= x_s[N-1];
				end
				2'd1: begin
					sin_val <= x_s[N-1];
					cos_val <= -y_s[N-1];
				end
				2'd2: begin
					sin_val <= -y_s[N-1];
					cos_val <= -x_s[N-1];
				end
				default: begin
					sin_val <= -x_s[N-1];
					cos_val <= y_s[N-1];
				end
			endcase
		end
	end

endmodule

/* src/gcd_isqrt.sv */
// Pipelined bitwise integer square root, one result bit per stage.
module gcd_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] radicand,
	output logic [30:0] root
);

	localparam int N = gcd_pkg::SQRT_STEPS;

	logic [61:0] n_s [N];
	logic [61:0] r_s [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
		logic [61:0] ni, ri, trial;
		if (k == 0) begin : g_first
			assign ni = {1'b0, radicand};
			assign ri = '0;
		end else begin : g_next
			assign ni = n_s[k-1];
			assign ri = r_s[k-1];
		end
		assign trial = ri + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (ni >= trial) begin
					n_s[k] <= ni - trial;
					r_s[k] <= (ri >> 1) + BIT;
				end else begin
					n_s[k] <= ni;
					r_s[k] <= ri >> 1;
				end
			end
		end
	end

	assign root = r_s[N-1][30:0];

endmodule

/* src/gcd_atan.sv */
// Pipelined vectoring CORDIC: angle of (x, y) as a binary angle.
module gcd_atan (
	input  logic               clk,
	input  logic               en,
	input  logic [30:0]        x_in,
	input  logic [30:0]        y_in,
	output logic signed [32:0] angle
);

	localparam int N = gcd_pkg::CORDIC_STEPS;

	logic signed [32:0] x_s [N];
	logic signed [32:0] y_s [N];
	logic signed [32:0] z_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [32:0] ANG = 33'(gcd_pkg::ATAN_TAB[i]);
		logic signed [32:0] xi, yi, zi, dx, dy;
		if (i == 0) begin : g_first
			assign xi = {2'b00, x_in};
			assign yi = {2'b00, y_in};
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end
		assign dx = yi >>> i;
		assign dy = xi >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi > 0) begin
					x_s[i] <= xi + dx;
					y_s[i] <= yi - dy;
					z_s[i] <= zi + ANG;
				end else begin
					x_s[i] <= xi - dx;
					y_s[i] <= yi + dy;
					z_s[i] <= zi - ANG;
				end
			end
		end
	end

	assign angle = z_s[N-1];

endmodule

/* src/great_circle_distance_core.sv */
// Haversine great-circle distance core: fully pipelined, one transaction per cycle.
// Pipeline from input transaction to result: two CORDIC chains of 25 and
// 24 stages, a 31-stage square root, and seven arithmetic stages.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset clears the valid bits only; the datapath registers carry no reset.
module great_circle_distance_core #(
	parameter int ANGLE_FRAC_BITS = gcd_pkg::ANGLE_FRAC_BITS,
	parameter int DIST_FRAC_BITS  = gcd_pkg::DIST_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [27:0] lat_a,
	input  logic signed [28:0] lon_a,
	input  logic signed [27:0] lat_b,
	input  logic signed [28:0] lon_b,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [22:0]        distance_km
);

	localparam int LAT = 2 + (gcd_pkg::CORDIC_STEPS + 1) + 3 + gcd_pkg::SQRT_STEPS
		+ gcd_pkg::CORDIC_STEPS + 2;
	localparam int SH = ANGLE_FRAC_BITS + 8;
	localparam int DSH = 48 - DIST_FRAC_BITS;
	localparam logic signed [32:0] CONV_H = 33'(gcd_pkg::CONV_HALF);
	localparam logic signed [32:0] CONV_F = 33'(gcd_pkg::CONV_FULL);
	localparam logic [16:0] SCALE_HI = gcd_pkg::DIST_SCALE[32:16];
	localparam logic [15:0] SCALE_LO = gcd_pkg::DIST_SCALE[15:0];
	localparam logic [65:0] ROUND = 66'(1) << (47 - DIST_FRAC_BITS);

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en = ~vld_q[LAT-1] | out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// angle differences
	logic signed [29:0] dlat_s1, dlon_s1, lata_s1, latb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= 30'(lat_b) - 30'(lat_a);
			dlon_s1 <= 30'(lon_b) - 30'(lon_a);
			lata_s1 <= 30'(lat_a);
			latb_s1 <= 30'(lat_b);
		end
	end

	// degrees to binary angle
	logic signed [63:0] p_dlat, p_dlon, p_lata, p_latb;
	logic [31:0]        bdlat_s2, bdlon_s2, blata_s2, blatb_s2;

	always_comb begin
		p_dlat = dlat_s1 * CONV_H;
		p_dlon = dlon_s1 * CONV_H;
		p_lata = lata_s1 * CONV_F;
		p_latb = latb_s1 * CONV_F;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bdlat_s2 <= p_dlat[SH+31:SH];
			bdlon_s2 <= p_dlon[SH+31:SH];
			blata_s2 <= p_lata[SH+31:SH];
			blatb_s2 <= p_latb[SH+31:SH];
		end
	end

	logic signed [32:0] sdl, sdn, ca, cb;

	gcd_sincos u_sc_dlat (.clk, .en, .bam(bdlat_s2), .sin_val(sdl), .cos_val());
	gcd_sincos u_sc_dlon (.clk, .en, .bam(bdlon_s2), .sin_val(sdn), .cos_val());
	gcd_sincos u_sc_lata (.clk, .en, .bam(blata_s2), .sin_val(), .cos_val(ca));
	gcd_sincos u_sc_latb (.clk, .en, .bam(blatb_s2), .sin_val(), .cos_val(cb));

	// squares and cosine product
	logic signed [65:0] sq_dl, sq_dn, pr_c;
	logic signed [32:0] s2_s3, n2_s3, pr_s3;

	always_comb begin
		sq_dl = sdl * sdl;
		sq_dn = sdn * sdn;
		pr_c  = ca * cb;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2_s3 <= 33'(sq_dl >>> 30);
			n2_s3 <= 33'(sq_dn >>> 30);
			pr_s3 <= 33'(pr_c >>> 30);
		end
	end

	logic signed [65:0] pn;
	logic signed [33:0] t2_s4;
	logic signed [32:0] s2_s4;

	assign pn = pr_s3 * n2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s4 <= 34'(pn >>> 30);
			s2_s4 <= s2_s3;
		end
	end

	// sum and clamp to [0, 1]
	logic signed [34:0] a_sum;
	logic [30:0]        a_s5;

	assign a_sum = 35'(s2_s4) + 35'(t2_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			if (a_sum < 0) begin
				a_s5 <= '0;
			end else if (a_sum > $signed({4'b0000, gcd_pkg::Q30_ONE})) begin
				a_s5 <= gcd_pkg::Q30_ONE;
			end else begin
				a_s5 <= a_sum[30:0];
			end
		end
	end

	logic [30:0] root_u, root_v, a_c;
	logic signed [32:0] ang;

	assign a_c = gcd_pkg::Q30_ONE - a_s5;

	gcd_isqrt u_sqrt_u (.clk, .en, .radicand({a_s5, 30'b0}), .root(root_u));
	gcd_isqrt u_sqrt_v (.clk, .en, .radicand({a_c, 30'b0}), .root(root_v));

	gcd_atan u_atan (.clk, .en, .x_in(root_v), .y_in(root_u), .angle(ang));

	// scale angle to distance in two partial products
	logic [31:0] t_pos;
	logic [48:0] ph_s6;
	logic [47:0] pl_s6;

	assign t_pos = (ang < 0) ? 32'd0 : ang[31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s6 <= t_pos * SCALE_HI;
			pl_s6 <= t_pos * SCALE_LO;
		end
	end

	logic [65:0] d_sum, d_shr;

	always_comb begin
		d_sum = (66'(ph_s6) << 16) + 66'(pl_s6) + ROUND;
		d_shr = d_sum >> DSH;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d_shr > 66'(gcd_pkg::OUT_MAX)) begin
				distance_km <= gcd_pkg::OUT_MAX;
			end else begin
				distance_km <= d_shr[22:0];
			end
		end
	end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the haversine great-circle distance core.
module testbench;

	typedef struct {
		int lat_a;
		int lon_a;
		int lat_b;
		int lon_b;
	} point_pair_t;

	localparam int DEG           = 1 << gcd_pkg::ANGLE_FRAC_BITS;
	localparam int LAT_RANGE     = 90 * DEG;
	localparam int LON_RANGE     = 180 * DEG;
	localparam int RANDOM_PAIRS  = 1450;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 120;
	localparam int ROUTE_ROWS    = 15;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [27:0] lat_a = '0;
	logic signed [28:0] lon_a = '0;
	logic signed [27:0] lat_b = '0;
	logic signed [28:0] lon_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [22:0]        distance_km;

	logic [22:0] distance_due[$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          send_calm = 0;
	int          recv_calm = 0;

	point_pair_t route_table [ROUTE_ROWS] = '{
		'{0, 0, 0, 0},
		'{LAT_RANGE, 0, -LAT_RANGE, 0},
		'{0, 0, 0, LON_RANGE},
		'{0, -LON_RANGE, 0, LON_RANGE},
		'{0, 90 * DEG, 0, -90 * DEG},
		'{45 * DEG, 45 * DEG, 45 * DEG, 45 * DEG},
		'{-LAT_RANGE, -LON_RANGE, LAT_RANGE, LON_RANGE},
		'{134217727, 268435455, -134217728, -268435456},
		'{-134217728, -268435456, 134217727, 268435455},
		'{134217727, 268435455, 134217727, 268435455},
		'{0, 0, 1, 0},
		'{0, 0, 0, 1},
		'{54001664, -125829, 51223757, 2464154},
		'{30 * DEG, 10 * DEG, -30 * DEG, -170 * DEG},
		'{-LAT_RANGE, 0, -LAT_RANGE, LON_RANGE}
	};

	great_circle_distance_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.lat_a(lat_a),
		.lon_a(lon_a),
		.lat_b(lat_b),
		.lon_b(lon_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.distance_km(distance_km)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [31:0] to_turn(longint deg, logic [31:0] conv);
		logic [63:0] p;
		p = longint'(deg) * longint'({32'd0, conv});
		return p[gcd_pkg::ANGLE_FRAC_BITS + 39 -: 32];
	endfunction

	function automatic void rotate_sin_cos(logic [31:0] turn, output longint s,
			output longint c);
		longint x, y, z, dx, dy;
		x = longint'(gcd_pkg::CORDIC_GAIN);
		y = 0;
		z = longint'(turn[29:0]);
		for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TAB[i]);
			end
		end
		case (turn[31:30])
			2'd0: begin s = y;  c = x;  end
			2'd1: begin s = x;  c = -y; end
			2'd2: begin s = -y; c = -x; end
			default: begin s = -x; c = y; end
		endcase
	endfunction

	function automatic longint vector_angle(longint x0, longint y0);
		longint x, y, z, dx, dy;
		x = x0;
		y = y0;
		z = 0;
		for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(gcd_pkg::ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(gcd_pkg::ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n0);
		longint unsigned n, r, b;
		n = n0;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [22:0] haversine_km(logic signed [27:0] la_i,
			logic signed [28:0] oa_i, logic signed [27:0] lb_i, logic signed [28:0] ob_i);
		longint la, oa, lb, ob;
		longint sdl, cdl, sdn, cdn, sa, ca, sb, cb;
		longint s2, n2, prod, a, t, one;
		longint unsigned u, v, d;
		la = la_i; oa = oa_i; lb = lb_i; ob = ob_i;
		one = longint'(gcd_pkg::Q30_ONE);
		rotate_sin_cos(to_turn(lb - la, gcd_pkg::CONV_HALF), sdl, cdl);
		rotate_sin_cos(to_turn(ob - oa, gcd_pkg::CONV_HALF), sdn, cdn);
		rotate_sin_cos(to_turn(la, gcd_pkg::CONV_FULL), sa, ca);
		rotate_sin_cos(to_turn(lb, gcd_pkg::CONV_FULL), sb, cb);
		s2 = (sdl * sdl) >>> 30;
		n2 = (sdn * sdn) >>> 30;
		prod = (ca * cb) >>> 30;
		a = s2 + ((prod * n2) >>> 30);
		if (a < 0) a = 0;
		if (a > one) a = one;
		u = root_floor(longint'(a) << 30);
		v = root_floor(longint'(one - a) << 30);
		t = vector_angle(longint'(v), longint'(u));
		if (t < 0) t = 0;
		d = (longint'(t) * longint'({31'd0, gcd_pkg::DIST_SCALE})
			+ (64'd1 << (47 - gcd_pkg::DIST_FRAC_BITS))) >> (48 - gcd_pkg::DIST_FRAC_BITS);
		if (d > longint'(gcd_pkg::OUT_MAX)) d = longint'(gcd_pkg::OUT_MAX);
		return d[22:0];
	endfunction

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 60);
		return $urandom_range(0, 17);
	endfunction

	function automatic int pick_edge(int range, int field_min, int field_max);
		case ($urandom_range(0, 5))
			0: return field_min;
			1: return field_max;
			2: return range;
			3: return -range;
			4: return 0;
			default: return int'($urandom_range(0, 2)) - 1;
		endcase
	endfunction

	function automatic point_pair_t random_pair();
		point_pair_t p;
		int kind;
		kind = $urandom_range(0, 9);
		p.lat_a = int'($urandom_range(0, 2 * LAT_RANGE)) - LAT_RANGE;
		p.lon_a = int'($urandom_range(0, 2 * LON_RANGE)) - LON_RANGE;
		p.lat_b = int'($urandom_range(0, 2 * LAT_RANGE)) - LAT_RANGE;
		p.lon_b = int'($urandom_range(0, 2 * LON_RANGE)) - LON_RANGE;
		case (kind)
			5, 6: begin
				p.lat_b = p.lat_a + int'($urandom_range(0, 1 << 17)) - (1 << 16);
				p.lon_b = p.lon_a + int'($urandom_range(0, 1 << 17)) - (1 << 16);
			end
			7: begin
				p.lat_a = $urandom; p.lon_a = $urandom;
				p.lat_b = $urandom; p.lon_b = $urandom;
			end
			8: begin
				p.lat_a = pick_edge(LAT_RANGE, -134217728, 134217727);
				p.lon_a = pick_edge(LON_RANGE, -268435456, 268435455);
				p.lat_b = pick_edge(LAT_RANGE, -134217728, 134217727);
				p.lon_b = pick_edge(LON_RANGE, -268435456, 268435455);
			end
			9: begin
				p.lat_b = -p.lat_a + int'($urandom_range(0, 64)) - 32;
				p.lon_b = p.lon_a + (p.lon_a > 0 ? -LON_RANGE : LON_RANGE)
					+ int'($urandom_range(0, 64)) - 32;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_pair(point_pair_t p);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		lat_a <= 28'(p.lat_a);
		lon_a <= 29'(p.lon_a);
		lat_b <= 28'(p.lat_b);
		lon_b <= 29'(p.lon_b);
		do @(posedge clk); while (!in_ready);
		distance_due.push_back(haversine_km(lat_a, lon_a, lat_b, lon_b));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (route_table[i]) send_pair(route_table[i]);
		repeat (RANDOM_PAIRS) send_pair(random_pair());
		in_valid <= 1'b0;
		while (distance_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		int gap;
		logic [22:0] want;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(recv_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (distance_due.size() == 0) begin
				$error("distance_km: unexpected transaction, actual %0d", distance_km);
				errors++;
			end else begin
				want = distance_due.pop_front();
				if (distance_km !== want) begin
					$error("distance_km: expected %0d, actual %0d", want, distance_km);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
